@@ rtl/gtcd_pkg.sv @@
// Shared types, constants and helpers for the gravity tilt change detector.
// No dependencies; imported by gtcd_mul_unit, gtcd_core and the top level.
package gtcd_pkg;

	localparam int AXIS_W      = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int DIFF_W      = AXIS_W + 1;
	localparam int ACC_W       = 2 * AXIS_W + 2;
	localparam int MAG_W       = 2 * AXIS_W;
	localparam int FACTOR_W    = 8;
	localparam int PROD_W      = MAG_W + FACTOR_W;
	localparam int SENS_W      = 2;
	localparam int EVENT_W     = 2;
	localparam int IN_TDATA_W  = 3 * AXIS_W;
	localparam int OUT_TDATA_W = 8;

	localparam logic [SENS_W-1:0] SENS_LOW    = 2'd0;
	localparam logic [SENS_W-1:0] SENS_MEDIUM = 2'd1;
	localparam logic [SENS_W-1:0] SENS_HIGH   = 2'd2;

	localparam logic [FACTOR_W-1:0] FACTOR_LOW    = 8'd5;
	localparam logic [FACTOR_W-1:0] FACTOR_MEDIUM = 8'd15;
	localparam logic [FACTOR_W-1:0] FACTOR_HIGH   = 8'd52;
	localparam logic [FACTOR_W-1:0] FACTOR_CLOSE  = 8'd130;

	localparam logic OP_CHECK   = 1'b0;
	localparam logic OP_CAPTURE = 1'b1;

	localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
	localparam logic [EVENT_W-1:0] EV_OPENED = 2'd1;
	localparam logic [EVENT_W-1:0] EV_CLOSED = 2'd2;

	// Multiplier operation select
	typedef struct packed {
		logic scale;    // 1: accumulator times factor, 0: square of axis difference
		logic capture;  // square the sample itself (reference taken as zero)
	} mul_ctl_t;

	function automatic logic signed [AXIS_W-1:0] sample_sext(input logic [AXIS_W-1:0] raw);
		logic signed [SAMPLE_BITS-1:0] t;
		t = raw[SAMPLE_BITS-1:0];
		return AXIS_W'(t);
	endfunction

	function automatic logic [FACTOR_W-1:0] open_factor(input logic [SENS_W-1:0] lvl);
		logic [FACTOR_W-1:0] f;
		unique case (lvl)
			SENS_LOW:    f = FACTOR_LOW;
			SENS_MEDIUM: f = FACTOR_MEDIUM;
			default:     f = FACTOR_HIGH;
		endcase
		return f;
	endfunction

endpackage

@@ rtl/gtcd_mul_unit.sv @@
// Shared arithmetic unit: axis difference, magnitude and one unsigned multiply.
// Used for the three squares and for the threshold scaling. Depends on gtcd_pkg.
module gtcd_mul_unit (
	input  gtcd_pkg::mul_ctl_t                       ctl,
	input  logic signed [gtcd_pkg::AXIS_W-1:0]       sample,
	input  logic signed [gtcd_pkg::AXIS_W-1:0]       refv,
	input  logic        [gtcd_pkg::MAG_W-1:0]        acc,
	input  logic        [gtcd_pkg::FACTOR_W-1:0]     factor,
	output logic        [gtcd_pkg::PROD_W-1:0]       product
);
	import gtcd_pkg::*;

	localparam int FULL_W = MAG_W + DIFF_W;

	logic signed [DIFF_W-1:0] diff;
	logic        [DIFF_W-1:0] absd;
	logic        [MAG_W-1:0]  op_a;
	logic        [DIFF_W-1:0] op_b;
	logic        [FULL_W-1:0] full;
	logic signed [AXIS_W-1:0] ref_eff;

	always_comb begin
		ref_eff = ctl.capture ? '0 : refv;
		diff    = DIFF_W'(sample) - DIFF_W'(ref_eff);
		absd    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		op_a    = ctl.scale ? acc : MAG_W'(absd);
		op_b    = ctl.scale ? DIFF_W'(factor) : absd;
		full    = FULL_W'(op_a) * FULL_W'(op_b);
		product = full[PROD_W-1:0];
	end

endmodule

@@ rtl/gtcd_core.sv @@
// Sequencer, reference state, decision logic and result register.
// Drives gtcd_mul_unit once per step. Depends on gtcd_pkg.
module gtcd_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic [gtcd_pkg::SENS_W-1:0]             sens,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    in_op,
	input  logic [gtcd_pkg::AXIS_W-1:0]             in_x,
	input  logic [gtcd_pkg::AXIS_W-1:0]             in_y,
	input  logic [gtcd_pkg::AXIS_W-1:0]             in_z,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [gtcd_pkg::EVENT_W-1:0]            out_event,
	output logic                                    out_displaced
);
	import gtcd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ0,
		ST_SQ1,
		ST_SQ2,
		ST_SUM,
		ST_SCALE,
		ST_DECIDE
	} state_t;

	state_t                    state_q;
	logic                      op_q;
	logic signed [AXIS_W-1:0]  samp_q [3];
	logic signed [AXIS_W-1:0]  ref_q  [3];
	logic        [MAG_W-1:0]   ref_mag_q;
	logic                      ref_present_q;
	logic                      open_q;
	logic        [ACC_W-1:0]   acc_q;
	logic        [PROD_W-1:0]  prod_q;
	logic                      out_valid_q;
	logic        [EVENT_W-1:0] event_q;
	logic                      disp_q;

	mul_ctl_t                  mctl;
	logic signed [AXIS_W-1:0]  mul_samp;
	logic signed [AXIS_W-1:0]  mul_ref;
	logic        [FACTOR_W-1:0] factor;
	logic        [PROD_W-1:0]  product;
	logic                      dist_above;
	logic                      out_free;

	always_comb begin
		unique case (state_q)
			ST_SQ1: begin
				mul_samp = samp_q[1];
				mul_ref  = ref_q[1];
			end
			ST_SQ2: begin
				mul_samp = samp_q[2];
				mul_ref  = ref_q[2];
			end
			default: begin
				mul_samp = samp_q[0];
				mul_ref  = ref_q[0];
			end
		endcase
		mctl.scale   = (state_q == ST_SCALE);
		mctl.capture = (op_q == OP_CAPTURE);
		factor       = open_q ? FACTOR_CLOSE : open_factor(sens);
		// scaled distance strictly above the reference magnitude
		dist_above   = (acc_q[ACC_W-1:MAG_W] != '0) || (prod_q > PROD_W'(ref_mag_q));
		out_free     = !out_valid_q || out_ready;
	end

	gtcd_mul_unit u_mul (
		.ctl     (mctl),
		.sample  (mul_samp),
		.refv    (mul_ref),
		.acc     (acc_q[MAG_W-1:0]),
		.factor  (factor),
		.product (product)
	);

	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign out_event     = event_q;
	assign out_displaced = disp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			op_q          <= OP_CHECK;
			samp_q[0]     <= '0;
			samp_q[1]     <= '0;
			samp_q[2]     <= '0;
			ref_q[0]      <= '0;
			ref_q[1]      <= '0;
			ref_q[2]      <= '0;
			ref_mag_q     <= '0;
			ref_present_q <= 1'b0;
			open_q        <= 1'b0;
			acc_q         <= '0;
			prod_q        <= '0;
			out_valid_q   <= 1'b0;
			event_q       <= EV_NONE;
			disp_q        <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_DECIDE))
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q      <= in_op;
						samp_q[0] <= sample_sext(in_x);
						samp_q[1] <= sample_sext(in_y);
						samp_q[2] <= sample_sext(in_z);
						acc_q     <= '0;
						prod_q    <= '0;
						state_q   <= ST_SQ0;
					end
				end
				ST_SQ0, ST_SQ1, ST_SQ2: begin
					acc_q   <= acc_q + ACC_W'(prod_q);
					prod_q  <= product;
					state_q <= (state_q == ST_SQ0) ? ST_SQ1 :
					           (state_q == ST_SQ1) ? ST_SQ2 : ST_SUM;
				end
				ST_SUM: begin
					acc_q   <= acc_q + ACC_W'(prod_q);
					state_q <= (op_q == OP_CAPTURE) ? ST_DECIDE : ST_SCALE;
				end
				ST_SCALE: begin
					prod_q  <= product;
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (op_q == OP_CAPTURE) begin
							ref_q[0]      <= samp_q[0];
							ref_q[1]      <= samp_q[1];
							ref_q[2]      <= samp_q[2];
							ref_mag_q     <= acc_q[MAG_W-1:0];
							ref_present_q <= (acc_q != '0);
							open_q        <= 1'b0;
							event_q       <= EV_NONE;
							disp_q        <= 1'b0;
						end else if (ref_present_q && !open_q && dist_above) begin
							open_q  <= 1'b1;
							event_q <= EV_OPENED;
							disp_q  <= 1'b1;
						end else if (ref_present_q && open_q && !dist_above) begin
							open_q  <= 1'b0;
							event_q <= EV_CLOSED;
							disp_q  <= 1'b0;
						end else begin
							event_q <= EV_NONE;
							disp_q  <= open_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_open_ev_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (event_q == EV_OPENED) |-> disp_q)
		else $error("opened event without displaced flag");

	a_close_ev_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (event_q == EV_CLOSED) |-> !disp_q)
		else $error("closed event with displaced flag");

	a_ref_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ref_present_q |-> (ref_mag_q != '0))
		else $error("reference present with zero magnitude");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accepting a transaction");

	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(event_q) && $stable(disp_q))
		else $error("pending result overwritten");
`endif

endmodule

@@ rtl/gravity_tilt_change_detector.sv @@
// Top level of the gravity tilt change detector: stream ports, sensitivity register.
// Instantiates gtcd_core (which holds gtcd_mul_unit). Depends on gtcd_pkg.
//
//  channel  | direction | handshake                      | payload
//  s_axis   | in        | s_axis_tvalid / s_axis_tready  | tdata x,y,z; tuser operation
//  m_axis   | out       | m_axis_tvalid / m_axis_tready  | tdata door_event, displaced_now
//  cfg      | in        | cfg_valid / cfg_ready          | cfg_data sensitivity_level
//
// A capture steps through the three axis squares, the sum and the decision; a check
// adds one threshold scaling on the single multiplier before the decision.
// Results sit in an output register; a new sample is taken while it waits.
// Reset clears the reference, open flag and sequencer and sets sensitivity to medium.
// A stalled result holds the sequencer in its last step until the register frees.
module gravity_tilt_change_detector (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [gtcd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // accel_x, accel_y, accel_z
	input  logic                                 s_axis_tuser,  // operation
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [gtcd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // door_event, displaced_now
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gtcd_pkg::SENS_W-1:0]          cfg_data       // sensitivity_level
);
	import gtcd_pkg::*;

	logic [SENS_W-1:0]  sens_q;
	logic [EVENT_W-1:0] door_event;
	logic               displaced_now;

	assign cfg_ready = 1'b1;

	// code 3 is kept as high sensitivity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q <= SENS_MEDIUM;
		end else if (cfg_valid && cfg_ready) begin
			sens_q <= (cfg_data > SENS_HIGH) ? SENS_HIGH : cfg_data;
		end
	end

	gtcd_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.sens          (sens_q),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_op         (s_axis_tuser),
		.in_x          (s_axis_tdata[AXIS_W-1:0]),
		.in_y          (s_axis_tdata[2*AXIS_W-1:AXIS_W]),
		.in_z          (s_axis_tdata[3*AXIS_W-1:2*AXIS_W]),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_event     (door_event),
		.out_displaced (displaced_now)
	);

	assign m_axis_tdata = {(OUT_TDATA_W - EVENT_W - 1)'(0), displaced_now, door_event};

endmodule
